// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that holds at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/lors_pkg.sv -----
// Types, codes and constants of the link owner recovery sequencer.
package lors_pkg;

    localparam int TAG_WIDTH = 16;
    localparam int GEN_W     = 16;
    localparam int TIME_W    = 64;
    localparam int CFG_W     = 32;
    localparam int HANDLE_W  = 16;

    localparam logic [GEN_W-1:0] GEN_MASK = (TAG_WIDTH >= GEN_W) ? {GEN_W{1'b1}} :
        GEN_W'((33'd1 << TAG_WIDTH) - 33'd1);

    typedef enum logic [2:0] {
        ACT_START      = 3'd0,
        ACT_OBSERVE    = 3'd1,
        ACT_TERM_FAIL  = 3'd2,
        ACT_TERM_RES   = 3'd3,
        ACT_HOST_SCHED = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_TERM       = 2'd1,
        PH_OWNER_LOSS = 2'd2,
        PH_HOST_RESET = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REQ_NONE       = 2'd0,
        REQ_TERMINATE  = 2'd1,
        REQ_HOST_RESET = 2'd2,
        REQ_COMPLETED  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        TR_ACCEPTED  = 2'd0,
        TR_RETRYABLE = 2'd1,
        TR_NOT_CONN  = 2'd2,
        TR_FAILED    = 2'd3
    } t_term_res;

    typedef enum logic [1:0] {
        CFG_TERM_BUDGET = 2'd0,
        CFG_OWNER_LOSS  = 2'd1,
        CFG_RETRY_DELAY = 2'd2,
        CFG_HOST_RETRY  = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_TERM_BUDGET = CFG_W'(2000000);
    localparam logic [CFG_W-1:0] RST_OWNER_LOSS  = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] RST_RETRY_DELAY = CFG_W'(50000);
    localparam logic [CFG_W-1:0] RST_HOST_RETRY  = CFG_W'(1000000);

    typedef struct packed {
        logic [CFG_W-1:0] term_budget;
        logic [CFG_W-1:0] owner_loss;
        logic [CFG_W-1:0] retry_delay;
        logic [CFG_W-1:0] host_retry;
    } t_cfg;

    typedef struct packed {
        logic [2:0]          action;
        logic [TIME_W-1:0]   now_us;
        logic                token_valid;
        logic [HANDLE_W-1:0] token_handle;
        logic [GEN_W-1:0]    token_generation;
        logic                snap_auth;
        logic                link_up;
        logic [1:0]          term_result;
    } t_item;

    typedef struct packed {
        logic   accepted;
        t_req   request;
        t_phase phase_now;
    } t_result;

endpackage

// ----- hw/rtl/lors_cfg.sv -----
// Configuration register bank of the recovery sequencer.
module lors_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic [1:0]               i_index,
    input  logic [31:0]              i_data,
    output lors_pkg::t_cfg           o_cfg
);
    import lors_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.term_budget <= RST_TERM_BUDGET;
            r_cfg.owner_loss  <= RST_OWNER_LOSS;
            r_cfg.retry_delay <= RST_RETRY_DELAY;
            r_cfg.host_retry  <= RST_HOST_RETRY;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_TERM_BUDGET: r_cfg.term_budget <= i_data;
                CFG_OWNER_LOSS:  r_cfg.owner_loss  <= i_data;
                CFG_RETRY_DELAY: r_cfg.retry_delay <= i_data;
                CFG_HOST_RETRY:  r_cfg.host_retry  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/lors_core.sv -----
// Sequencer state and the per-word phase, request and timer logic.
module lors_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lors_pkg::t_item  i_item,
    input  lors_pkg::t_cfg   i_cfg,
    output lors_pkg::t_result o_result
);
    import lors_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [GEN_W-1:0]    r_gen,    n_gen;
    logic [TIME_W-1:0]   r_hold,   n_hold;
    logic [TIME_W-1:0]   r_dead,   n_dead;

    logic [GEN_W-1:0]    gen_in;
    logic [CFG_W-1:0]    addend;
    logic [TIME_W-1:0]   sum;
    logic                past_dead;
    logic                before_hold;
    logic                mismatch;
    t_action             act;
    t_term_res           tres;

    assign act    = t_action'(i_item.action);
    assign tres   = t_term_res'(i_item.term_result);
    assign gen_in = i_item.token_generation & GEN_MASK;

    // One shared adder: pick the interval that this action rearms with.
    always_comb begin
        addend = '0;
        unique case (act)
            ACT_START:      addend = i_cfg.term_budget;
            ACT_TERM_RES: begin
                if (tres == TR_ACCEPTED) begin
                    addend = i_cfg.owner_loss;
                end else if (tres == TR_RETRYABLE) begin
                    addend = i_cfg.retry_delay;
                end
            end
            ACT_HOST_SCHED: addend = i_cfg.host_retry;
            default: ;
        endcase
    end

    assign sum         = i_item.now_us + TIME_W'(addend);
    assign past_dead   = i_item.now_us >= r_dead;
    assign before_hold = i_item.now_us < r_hold;
    assign mismatch    = !i_item.link_up || !i_item.token_valid ||
                         (i_item.token_handle != r_handle) || (gen_in != r_gen);

    always_comb begin
        n_phase  = r_phase;
        n_handle = r_handle;
        n_gen    = r_gen;
        n_hold   = r_hold;
        n_dead   = r_dead;
        o_result.accepted  = 1'b0;
        o_result.request   = REQ_NONE;

        unique case (act)
            ACT_START: begin
                if (!i_item.token_valid) begin
                    n_phase  = PH_IDLE;
                    n_handle = '0;
                    n_gen    = '0;
                    n_hold   = '0;
                    n_dead   = '0;
                end else begin
                    n_phase  = PH_TERM;
                    n_handle = i_item.token_handle;
                    n_gen    = gen_in;
                    n_hold   = i_item.now_us;
                    n_dead   = sum;
                    o_result.accepted = 1'b1;
                end
            end
            ACT_OBSERVE: begin
                priority if (r_phase == PH_IDLE) begin
                    o_result.request = REQ_NONE;
                end else if (i_item.snap_auth && mismatch) begin
                    n_phase  = PH_IDLE;
                    n_handle = '0;
                    n_gen    = '0;
                    n_hold   = '0;
                    n_dead   = '0;
                    o_result.request = REQ_COMPLETED;
                end else if (r_phase == PH_TERM) begin
                    priority if (past_dead) begin
                        n_phase = PH_HOST_RESET;
                        o_result.request = REQ_HOST_RESET;
                    end else if (before_hold) begin
                        o_result.request = REQ_NONE;
                    end else begin
                        o_result.request = REQ_TERMINATE;
                    end
                end else if (before_hold) begin
                    o_result.request = REQ_NONE;
                end else begin
                    n_phase = PH_HOST_RESET;
                    o_result.request = REQ_HOST_RESET;
                end
            end
            ACT_TERM_FAIL: begin
                if (r_phase != PH_IDLE && r_handle == i_item.token_handle) begin
                    n_phase = PH_HOST_RESET;
                    n_hold  = i_item.now_us;
                    o_result.accepted = 1'b1;
                end
            end
            ACT_TERM_RES: begin
                if (r_phase != PH_IDLE) begin
                    unique case (tres)
                        TR_ACCEPTED: begin
                            n_phase = PH_OWNER_LOSS;
                            n_hold  = sum;
                        end
                        TR_RETRYABLE: begin
                            n_phase = PH_TERM;
                            n_hold  = sum;
                        end
                        default: begin
                            n_phase = PH_HOST_RESET;
                            n_hold  = i_item.now_us;
                        end
                    endcase
                end
            end
            ACT_HOST_SCHED: begin
                if (r_phase == PH_HOST_RESET) begin
                    n_hold = sum;
                end
            end
            ACT_CLEAR: begin
                n_phase  = PH_IDLE;
                n_handle = '0;
                n_gen    = '0;
                n_hold   = '0;
                n_dead   = '0;
            end
            default: ;
        endcase

        o_result.phase_now = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_handle <= '0;
            r_gen    <= '0;
            r_hold   <= '0;
            r_dead   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_handle <= n_handle;
            r_gen    <= n_gen;
            r_hold   <= n_hold;
            r_dead   <= n_dead;
        end
    end

endmodule

// ----- hw/rtl/link_owner_recovery_sequencer_top.sv -----
// Words pass the input register and the core into the result register, one per cycle
// unless the result is held; the next word uses the state left by the one before.
// The input register takes one more word behind a held result; input stalls only
// while both the input and the result register are full and the result is held.
// Reset is synchronous, active low: phase idle, targets and timers zero,
// configuration registers at their defaults, both channels empty.
module link_owner_recovery_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_now_us,
    input  logic        i_token_valid,
    input  logic [15:0] i_token_handle,
    input  logic [15:0] i_token_generation,
    input  logic        i_snap_auth,
    input  logic        i_link_up,
    input  logic [1:0]  i_term_result,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted,
    output logic [1:0]  o_request,
    output logic [1:0]  o_phase_now
);
    import lors_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    logic    r_out_vld;
    t_result r_res;
    t_result res;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    lors_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Move the staged word into the result register when that is free or drains.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.action           <= i_action;
            r_item.now_us           <= i_now_us;
            r_item.token_valid      <= i_token_valid;
            r_item.token_handle     <= i_token_handle;
            r_item.token_generation <= i_token_generation;
            r_item.snap_auth        <= i_snap_auth;
            r_item.link_up          <= i_link_up;
            r_item.term_result      <= i_term_result;
        end
    end

    lors_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_accepted  = r_res.accepted;
    assign o_request   = r_res.request;
    assign o_phase_now = r_res.phase_now;

endmodule

// ----- hw/rtl/lors_checker.sv -----
// Port-level checks of the recovery sequencer and their binding to the top level.
`include "assert_macros.svh"

module lors_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_accepted,
    input logic [1:0] o_request,
    input logic [1:0] o_phase_now
);
    import lors_pkg::*;

    // A held result keeps its word.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_accepted) &&
        $stable(o_request) && $stable(o_phase_now)))

    // Input stalls only behind a full, stalled result register.
    `ASSERT_CLK(a_in_stall, i_clk, i_rst_n, !o_in_ready |-> (o_out_valid && !i_out_ready))

    // A taken start or terminate failure always leaves a live phase.
    `ASSERT_CLK(a_acc_phase, i_clk, i_rst_n,
        (o_out_valid && o_accepted) |-> (o_phase_now != PH_IDLE && o_request == REQ_NONE))

    // Completion drops back to idle.
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n,
        (o_out_valid && o_request == REQ_COMPLETED) |-> (o_phase_now == PH_IDLE))

    // Both channels come out of reset empty.
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !$past(i_rst_n) |-> (!o_out_valid && o_in_ready))

endmodule

bind link_owner_recovery_sequencer_top lors_checker u_lors_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_accepted  (o_accepted),
    .o_request   (o_request),
    .o_phase_now (o_phase_now)
);
